// ----- rtl/prss_pkg.sv -----
// ----------------------------------------------------------------------------
// prss_pkg
// Shared types and helpers for the priority score selection sort block:
// the stored record layout, the result beat layout and the sequencer states.
// ----------------------------------------------------------------------------
package prss_pkg;

   localparam int unsigned ScoreWidth = 10;
   localparam int unsigned RankWidth  = 5;

   // one stored record, 40 bits
   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  emergency;
      logic [7:0]  severity;
      logic [7:0]  degree;
   } rec_type;

   // one result beat as handed to the output register
   typedef struct packed {
      rec_type                rec;
      logic [ScoreWidth-1:0]  score;
      logic [RankWidth-1:0]   rank;
      logic                   entry_valid;
      logic                   overflowed;
      logic                   last_result;
   } result_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_EMPTY = 4'b1000
   } state_type;

   // score is the plain sum of the three levels, at most 765
   function automatic logic [ScoreWidth-1:0] score_of(input rec_type r);
      score_of = ScoreWidth'(r.emergency) + ScoreWidth'(r.severity)
               + ScoreWidth'(r.degree);
   endfunction

endpackage

// ----- rtl/priority_score_selection_sort_top.sv -----
// ----------------------------------------------------------------------------
// priority_score_selection_sort_top
// Collects request records and emits them ranked by score, highest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel req_*: one record per beat, accepted when req_valid is high
//   and req_stall is low. Records with req_admitted set are stored in arrival
//   order up to MAX_RECORDS; further admitted records are dropped and flagged.
//   A beat with req_last_item set closes the batch. req_stall then stays high
//   while the store is ranked: pass i streams entries i..n-1 out of the store
//   (one read per cycle, through the registered read port) and then emits its
//   winner; the ranking time is set by the single read port of the store.
//   Output channel rsp_*: one beat per ranked record, rank 0 first, with
//   rsp_last_result on the final one; an empty batch gives a single beat with
//   rsp_entry_valid low. Results sit in an output register; when the receiver
//   holds rsp_stall the ranking halts at the next emit and resumes once the
//   register drains. Loading of the next batch starts after the last beat is
//   in the output register.
//   Reset (synchronous, active high) empties the store, clears the overflow
//   flag and the valid flag of the output register.
// ----------------------------------------------------------------------------
module priority_score_selection_sort_top #(
   parameter int unsigned MAX_RECORDS = 32
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [15:0]  req_request_id,
   input  logic [7:0]   req_emergency_level,
   input  logic [7:0]   req_severity_level,
   input  logic [7:0]   req_conflict_degree,
   input  logic         req_admitted,
   input  logic         req_last_item,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [15:0]  rsp_out_id,
   output logic [7:0]   rsp_out_emergency,
   output logic [7:0]   rsp_out_severity,
   output logic [7:0]   rsp_out_degree,
   output logic [9:0]   rsp_out_score,
   output logic [4:0]   rsp_rank_index,
   output logic         rsp_entry_valid,
   output logic         rsp_overflowed,
   output logic         rsp_last_result
);

   localparam int unsigned AW = $clog2(MAX_RECORDS);
   localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

   prss_pkg::rec_type     req_rec;
   prss_pkg::rec_type     wr_data;
   prss_pkg::rec_type     rd_data;
   prss_pkg::result_type  res;
   prss_pkg::result_type  rsp_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  wr_en;
   logic                  rd_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic                  res_load;
   logic                  out_free;

   // pack the request beat
   assign req_rec.id        = req_request_id;
   assign req_rec.emergency = req_emergency_level;
   assign req_rec.severity  = req_severity_level;
   assign req_rec.degree    = req_conflict_degree;

   prss_store #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   prss_rank_engine #(
      .MAX_RECORDS (MAX_RECORDS),
      .AW          (AW),
      .CW          (CW)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_rec       (req_rec),
      .req_admitted  (req_admitted),
      .req_last_item (req_last_item),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .out_free      (out_free),
      .res_load      (res_load),
      .res           (res)
   );

   // output register takes a new beat when empty or draining
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   // response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_id        = rsp_ff.rec.id;
   assign rsp_out_emergency = rsp_ff.rec.emergency;
   assign rsp_out_severity  = rsp_ff.rec.severity;
   assign rsp_out_degree    = rsp_ff.rec.degree;
   assign rsp_out_score     = rsp_ff.score;
   assign rsp_rank_index    = rsp_ff.rank;
   assign rsp_entry_valid   = rsp_ff.entry_valid;
   assign rsp_overflowed    = rsp_ff.overflowed;
   assign rsp_last_result   = rsp_ff.last_result;

endmodule

// ----- rtl/prss_store.sv -----
// ----------------------------------------------------------------------------
// prss_store
// Record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prss_store #(
   parameter int unsigned MAX_RECORDS = 32,
   parameter int unsigned AW          = 5
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  prss_pkg::rec_type   wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output prss_pkg::rec_type   rd_data
);

   prss_pkg::rec_type mem [MAX_RECORDS];
   prss_pkg::rec_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/prss_rank_engine.sv -----
// ----------------------------------------------------------------------------
// prss_rank_engine
// Sequencer for the record store: loads admitted records, then runs one
// selection pass per rank position by streaming the unsorted tail out of the
// store, and writes the displaced record back into the winner's slot.
// ----------------------------------------------------------------------------
module prss_rank_engine #(
   parameter int unsigned MAX_RECORDS = 32,
   parameter int unsigned AW          = 5,
   parameter int unsigned CW          = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  prss_pkg::rec_type      req_rec,
   input  logic                   req_admitted,
   input  logic                   req_last_item,
   // store ports
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output prss_pkg::rec_type      wr_data,
   output logic                   rd_en,
   output logic [AW-1:0]          rd_addr,
   input  prss_pkg::rec_type      rd_data,
   // result hand-off
   input  logic                   out_free,
   output logic                   res_load,
   output prss_pkg::result_type   res
);

   localparam logic [CW-1:0] Capacity = CW'(MAX_RECORDS);

   prss_pkg::state_type                  state_ff, state_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic                                 ovf_ff, ovf_in;
   logic [AW-1:0]                        pos_ff, pos_in;
   logic [CW-1:0]                        rd_ptr_ff, rd_ptr_in;
   logic                                 rd_vld_ff;
   logic [AW-1:0]                        rd_idx_ff;
   prss_pkg::rec_type                    cur_ff, cur_in;
   prss_pkg::rec_type                    best_ff, best_in;
   logic [prss_pkg::ScoreWidth-1:0]      best_score_ff, best_score_in;
   logic [AW-1:0]                        best_idx_ff, best_idx_in;

   logic                                 accept;
   logic                                 store_it;
   logic [CW-1:0]                        load_count;
   logic [prss_pkg::ScoreWidth-1:0]      rd_score;
   logic                                 pos_is_last;

   assign req_stall   = (state_ff != prss_pkg::ST_LOAD);
   assign accept      = req_valid && !req_stall;
   assign store_it    = accept && req_admitted && (count_ff < Capacity);
   assign load_count  = count_ff + CW'(store_it);
   assign rd_score    = prss_pkg::score_of(rd_data);
   assign pos_is_last = ((CW'(pos_ff) + CW'(1)) == count_ff);

   // read issue runs ahead over the unsorted tail
   assign rd_en   = (state_ff == prss_pkg::ST_SCAN) && (rd_ptr_ff < count_ff);
   assign rd_addr = rd_ptr_ff[AW-1:0];

   // write mux: load appends, emit puts the displaced record into the winner slot
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[AW-1:0];
      wr_data = req_rec;
      if (state_ff == prss_pkg::ST_LOAD) begin
         wr_en = store_it;
      end else if (state_ff == prss_pkg::ST_EMIT) begin
         wr_en   = out_free;
         wr_addr = best_idx_ff;
         wr_data = cur_ff;
      end
   end

   // result beat
   always_comb begin
      res             = '0;
      res.overflowed  = ovf_ff;
      res.last_result = 1'b1;
      res_load        = 1'b0;
      if (state_ff == prss_pkg::ST_EMIT) begin
         res_load        = out_free;
         res.rec         = best_ff;
         res.score       = best_score_ff;
         res.rank        = prss_pkg::RankWidth'(pos_ff);
         res.entry_valid = 1'b1;
         res.last_result = pos_is_last;
      end else if (state_ff == prss_pkg::ST_EMPTY) begin
         res_load = out_free;
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      rd_ptr_in     = rd_ptr_ff;
      cur_in        = cur_ff;
      best_in       = best_ff;
      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      unique case (state_ff)
         prss_pkg::ST_LOAD: begin
            if (accept) begin
               count_in = load_count;
               if (req_admitted && !store_it) begin
                  ovf_in = 1'b1;
               end
               if (req_last_item) begin
                  pos_in    = '0;
                  rd_ptr_in = '0;
                  state_in  = (load_count == '0) ? prss_pkg::ST_EMPTY : prss_pkg::ST_SCAN;
               end
            end
         end
         prss_pkg::ST_SCAN: begin
            if (rd_en) begin
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end
            if (rd_vld_ff) begin
               // first read of a pass is the slot itself and seeds the winner
               if (rd_idx_ff == pos_ff) begin
                  cur_in        = rd_data;
                  best_in       = rd_data;
                  best_score_in = rd_score;
                  best_idx_in   = rd_idx_ff;
               end else if (rd_score > best_score_ff) begin
                  best_in       = rd_data;
                  best_score_in = rd_score;
                  best_idx_in   = rd_idx_ff;
               end
               if ((CW'(rd_idx_ff) + CW'(1)) == count_ff) begin
                  state_in = prss_pkg::ST_EMIT;
               end
            end
         end
         prss_pkg::ST_EMIT: begin
            if (out_free) begin
               if (pos_is_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = prss_pkg::ST_LOAD;
               end else begin
                  pos_in    = pos_ff + AW'(1);
                  rd_ptr_in = CW'(pos_ff) + CW'(1);
                  state_in  = prss_pkg::ST_SCAN;
               end
            end
         end
         prss_pkg::ST_EMPTY: begin
            if (out_free) begin
               ovf_in   = 1'b0;
               state_in = prss_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = prss_pkg::ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= prss_pkg::ST_LOAD;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         pos_ff    <= '0;
         rd_ptr_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         pos_ff    <= pos_in;
         rd_ptr_ff <= rd_ptr_in;
         rd_vld_ff <= rd_en;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_addr;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      best_score_ff <= best_score_in;
      best_idx_ff   <= best_idx_in;
   end

   // store never holds more than its capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Capacity)
      else $error("record count above capacity");

   // a pass always targets a stored slot
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prss_pkg::ST_SCAN || state_ff == prss_pkg::ST_EMIT)
         |-> (CW'(pos_ff) < count_ff))
      else $error("rank position outside stored records");

   // the winner never comes from the already ranked head
   a_winner_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == prss_pkg::ST_EMIT) |-> (best_idx_ff >= pos_ff))
      else $error("winner index below rank position");

   // the final beat of a run returns to loading with the batch cleared
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (res_load && res.last_result)
         |=> (state_ff == prss_pkg::ST_LOAD && count_ff == '0 && !ovf_ff))
      else $error("batch state not cleared after last beat");

endmodule
